>>> rtl/tsbs_pkg.sv
// Package for the touch stroke Bezier smoother: widths, reset values and output limits.
// No dependencies.
package tsbs_pkg;
    localparam int COORD_BITS_DEF  = 12;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int CP_FRAC         = 8;
    localparam int OUT_W           = 15;
    localparam int STEP_W          = 6;
    localparam logic [STEP_W-1:0] STEPS_RESET = 6'd50;
    localparam int OUT_MAX = 16383;
    localparam int OUT_MIN = -16384;
endpackage

>>> rtl/tsbs_front.sv
// Front end: accepts samples, tracks stroke state and queues segment commands.
// Depends on tsbs_pkg.
module tsbs_front import tsbs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [11:0]           i_x_pos,
    input  logic [11:0]           i_y_pos,
    input  logic                  i_release_req,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output logic [6*COORD_BITS+2-1:0] o_cmd
);
    localparam int CW = 6*COORD_BITS+2;
    logic [COORD_BITS-1:0] r_ox, r_oy, r_nx, r_ny;
    logic [1:0] r_cnt;
    // two-entry queue
    logic [CW-1:0] r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_fill;
    logic acc, push, pop;
    logic [1:0] cnt_eff;
    logic [COORD_BITS-1:0] x, y;

    assign x = COORD_BITS'(i_x_pos);
    assign y = COORD_BITS'(i_y_pos);
    assign o_ready = (r_fill != 2'd2);
    assign acc = i_valid && o_ready;
    assign cnt_eff = i_release_req ? 2'd0 : r_cnt;
    assign push = acc && (i_y_pos != 12'd0);
    assign pop = o_cmd_valid && i_cmd_ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0; r_oy <= '0; r_nx <= '0; r_ny <= '0;
            r_cnt <= '0; r_wp <= 1'b0; r_rp <= 1'b0; r_fill <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= {cnt_eff, r_ox, r_oy, r_nx, r_ny, x, y};
                r_wp <= ~r_wp;
                r_ox <= r_nx; r_oy <= r_ny; r_nx <= x; r_ny <= y;
                r_cnt <= (cnt_eff == 2'd3) ? 2'd3 : cnt_eff + 2'd1;
            end else if (acc && i_release_req) begin
                r_cnt <= '0;
            end
            if (pop) r_rp <= ~r_rp;
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2) else $error("queue overfill");
    a_nopush_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd2) |-> !push) else $error("push into full queue");
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_cnt) == 2'd3 && !$past(acc && i_release_req)) |-> r_cnt == 2'd3)
        else $error("stroke count left saturation");
endmodule

>>> rtl/tsbs_back.sv
// Back end: parameter division, control point solve and curve sample emission.
// Depends on tsbs_pkg.
module tsbs_back import tsbs_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [STEP_W-1:0]        i_steps,
    input  logic                     i_cmd_valid,
    output logic                     o_cmd_ready,
    input  logic [6*COORD_BITS+2-1:0] i_cmd,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [OUT_W-1:0]  o_out_x,
    output logic signed [OUT_W-1:0]  o_out_y,
    output logic                     o_retract_previous,
    output logic                     o_last
);
    localparam int TF = T_FRAC_BITS;
    localparam int CB = COORD_BITS;
    localparam int DW = 2*CB+2;            // dot / len width (unsigned)
    localparam int NW = CB+TF+2;           // control numerator magnitude
    // dividend width: covers dot<<TF as well as the control point dividend
    localparam int QW = (NW+CP_FRAC+1 > DW+TF) ? NW+CP_FRAC+1 : DW+TF;
    localparam int AW = CB+CP_FRAC+TF+6;   // curve accumulator width
    localparam int CTW = $clog2(QW+1);
    localparam logic [TF:0] ONE = (TF+1)'(1) << TF;
    localparam logic [TF:0] TLO = (TF+1)'(1) << (TF-6);
    localparam logic [TF:0] THI = ONE - TLO;

    localparam logic [3:0] S_IDLE = 4'd0, S_DOT = 4'd1, S_TDIV = 4'd2,
        S_TCL = 4'd3, S_W = 4'd4, S_NUM = 4'd5, S_CDIV = 4'd6, S_CFIX = 4'd7,
        S_SDIV = 4'd8, S_SW = 4'd9, S_ACC = 4'd10, S_OUT = 4'd11,
        S_END = 4'd12, S_SW2 = 4'd13;

    logic [3:0] r_st;
    logic [1:0] r_cnt;
    logic [CB-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic [DW-1:0] r_dot, r_len;
    logic r_dot_neg;
    logic [TF:0] r_t, r_s, r_s0;
    logic [TF:0] r_w0, r_w2, r_wd;
    logic r_axis;                  // 0: x, 1: y
    logic signed [NW:0] r_num;
    logic [QW-1:0] r_quo;
    logic [QW:0] r_rem;
    logic [QW-1:0] r_div;
    logic [CTW-1:0] r_bit;
    logic signed [NW+1:0] r_cx, r_cy;
    logic [STEP_W-1:0] r_k, r_n;
    logic [TF:0] r_a, r_b, r_e;
    logic signed [AW-1:0] r_acc;
    logic signed [OUT_W-1:0] r_px;
    logic r_first;
    logic r_ov;
    logic signed [OUT_W-1:0] r_ox, r_oy;
    logic r_oret, r_olast;
    logic [1:0] r_wsel;

    logic signed [CB+1:0] dx, dy, d1x, d1y;
    logic [TF:0] mul_a, mul_b, mul_r;
    logic [2*TF+2:0] mul_p;
    logic signed [CB:0] p0, p1, p2;
    logic signed [NW+1:0] cval;
    logic signed [AW-1:0] term, rnd;
    logic signed [AW-1:0] sh;
    logic signed [OUT_W-1:0] sat;
    logic out_free;
    logic load;

    assign out_free = !r_ov || i_ready;
    // a result enters the output register this cycle
    assign load = out_free && ((r_st == S_OUT && r_axis)
                            || (r_st == S_END && r_cnt != 2'd1));
    assign o_valid = r_ov;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
    assign o_retract_previous = r_oret;
    assign o_last = r_olast;
    assign o_cmd_ready = (r_st == S_IDLE);

    assign dx  = $signed({2'b0, r_x2}) - $signed({2'b0, r_x0});
    assign dy  = $signed({2'b0, r_y2}) - $signed({2'b0, r_y0});
    assign d1x = $signed({2'b0, r_x1}) - $signed({2'b0, r_x0});
    assign d1y = $signed({2'b0, r_y1}) - $signed({2'b0, r_y0});
    assign p0 = $signed({1'b0, r_axis ? r_y0 : r_x0});
    assign p1 = $signed({1'b0, r_axis ? r_y1 : r_x1});
    assign p2 = $signed({1'b0, r_axis ? r_y2 : r_x2});
    assign cval = r_axis ? r_cy : r_cx;

    // shared Q1.TF multiplier, rounded half up
    always_comb begin
        unique case (r_wsel)
            2'd0: begin mul_a = ONE - r_s; mul_b = ONE - r_s; end
            2'd1: begin mul_a = r_s; mul_b = r_s; end
            default: begin mul_a = ONE - r_s; mul_b = r_s; end
        endcase
        mul_p = (2*TF+3)'(mul_a) * (2*TF+3)'(mul_b)
              + ((2*TF+3)'(1) << (TF-1));
        mul_r = mul_p[2*TF:TF];
    end

    always_comb begin
        unique case (r_wsel)
            2'd0: term = AW'(r_a) * AW'(p0) * AW'(1 << CP_FRAC);
            2'd1: term = AW'(r_e) * AW'(p2) * AW'(1 << CP_FRAC);
            default: term = AW'(r_b) * AW'(cval);
        endcase
        rnd = r_acc + (AW'(1) <<< (TF+CP_FRAC-1));
        sh = rnd >>> (TF+CP_FRAC);
        if (sh < AW'(OUT_MIN)) sat = OUT_W'(OUT_MIN);
        else if (sh > AW'(OUT_MAX)) sat = OUT_W'(OUT_MAX);
        else sat = sh[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_ov <= load || (r_ov && !i_ready);
            unique case (r_st)
                S_IDLE: if (i_cmd_valid) begin
                    {r_cnt, r_x0, r_y0, r_x1, r_y1, r_x2, r_y2} <= i_cmd;
                    r_n <= (i_steps < 6'd2) ? 6'd2 : i_steps;
                    r_first <= 1'b1;
                    r_st <= (i_cmd[6*CB+1:6*CB] >= 2'd2) ? S_DOT : S_END;
                end
                S_DOT: begin
                    r_len <= DW'(dx*dx + dy*dy);
                    r_dot <= DW'(d1x*dx + d1y*dy);
                    r_dot_neg <= (d1x*dx + d1y*dy) <= 0;
                    r_st <= S_TCL;
                end
                S_TCL: begin
                    if (r_len == '0) begin r_t <= ONE >> 1; r_st <= S_W; end
                    else if (r_dot_neg) begin r_t <= TLO; r_st <= S_W; end
                    else if (r_dot >= r_len) begin r_t <= THI; r_st <= S_W; end
                    else begin
                        // restoring divide: dot<<TF / len
                        r_quo <= QW'(r_dot) << TF;
                        r_rem <= '0;
                        r_div <= QW'(r_len);
                        r_bit <= CTW'(QW);
                        r_st <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (r_bit == '0) begin
                        if (r_quo[TF:0] < TLO) r_t <= TLO;
                        else if (r_quo[TF:0] > THI) r_t <= THI;
                        else r_t <= r_quo[TF:0];
                        r_st <= S_W;
                    end else begin
                        logic [QW:0] rs;
                        rs = {r_rem[QW-1:0], r_quo[QW-1]};
                        if (rs >= {1'b0, r_div}) begin
                            r_rem <= rs - {1'b0, r_div};
                            r_quo <= {r_quo[QW-2:0], 1'b1};
                        end else begin
                            r_rem <= rs;
                            r_quo <= {r_quo[QW-2:0], 1'b0};
                        end
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_W: begin
                    // weights at t, one per cycle via the shared multiplier
                    r_s <= r_t;
                    r_wsel <= 2'd0;
                    r_axis <= 1'b0;
                    r_st <= S_SW2;
                end
                S_SW2: begin
                    unique case (r_wsel)
                        2'd0: begin r_w0 <= mul_r; r_wsel <= 2'd1; end
                        2'd1: begin r_w2 <= mul_r; r_wsel <= 2'd2; end
                        default: begin
                            r_wd <= mul_r;  // (1-t)*t; S_NUM replaces it with 2(1-t)t, doubled before rounding
                            r_wsel <= 2'd3;
                            r_st <= S_NUM;
                        end
                    endcase
                end
                S_NUM: begin
                    logic [2*TF+2:0] dd;
                    dd = (2*TF+3)'(ONE - r_t) * (2*TF+3)'(r_t) * 2
                       + ((2*TF+3)'(1) << (TF-1));
                    r_wd <= dd[2*TF:TF];
                    r_num <= (NW+1)'(p1 * $signed({1'b0, ONE}))
                           - (NW+1)'($signed({1'b0, r_w0}) * p0)
                           - (NW+1)'($signed({1'b0, r_w2}) * p2);
                    r_st <= S_CFIX;
                end
                S_CFIX: begin
                    logic [NW-1:0] mag;
                    mag = r_num[NW] ? NW'(-r_num) : NW'(r_num);
                    if (r_wd == '0) begin
                        if (r_axis) begin r_cy <= '0; r_st <= S_SDIV; r_k <= '0; end
                        else begin r_cx <= '0; r_axis <= 1'b1; r_st <= S_NUM; end
                    end else begin
                        r_quo <= (QW'(mag) << CP_FRAC) + QW'(r_wd >> 1);
                        r_rem <= '0;
                        r_div <= QW'(r_wd);
                        r_bit <= CTW'(QW);
                        r_st <= S_CDIV;
                    end
                end
                S_CDIV: begin
                    if (r_bit == '0) begin
                        logic signed [NW+1:0] q;
                        q = r_num[NW] ? -(NW+2)'(r_quo) : (NW+2)'(r_quo);
                        if (r_axis) begin r_cy <= q; r_st <= S_SDIV; r_k <= '0; end
                        else begin r_cx <= q; r_axis <= 1'b1; r_st <= S_NUM; end
                    end else begin
                        logic [QW:0] rs;
                        rs = {r_rem[QW-1:0], r_quo[QW-1]};
                        if (rs >= {1'b0, r_div}) begin
                            r_rem <= rs - {1'b0, r_div};
                            r_quo <= {r_quo[QW-2:0], 1'b1};
                        end else begin
                            r_rem <= rs;
                            r_quo <= {r_quo[QW-2:0], 1'b0};
                        end
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_SDIV: begin
                    // step offset k*2^TF/N by restoring divide
                    if (r_k == r_n) r_st <= S_END;
                    else begin
                        r_s0 <= (r_cnt == 2'd2) ? '0 : r_t;
                        r_quo <= QW'(r_k) << TF;
                        r_rem <= '0;
                        r_div <= QW'(r_n);
                        r_bit <= CTW'(QW);
                        r_st <= S_SW;
                    end
                end
                S_SW: begin
                    if (r_bit == '0) begin
                        logic [TF+1:0] s;
                        s = (TF+2)'(r_s0) + (TF+2)'(r_quo[TF:0]);
                        if (s >= (TF+2)'(ONE)) r_st <= S_END;
                        else begin
                            r_s <= s[TF:0];
                            r_wsel <= 2'd0;
                            r_axis <= 1'b0;
                            r_acc <= '0;
                            r_st <= S_ACC;
                            r_bit <= CTW'(1);
                        end
                    end else begin
                        logic [QW:0] rs;
                        rs = {r_rem[QW-1:0], r_quo[QW-1]};
                        if (rs >= {1'b0, r_div}) begin
                            r_rem <= rs - {1'b0, r_div};
                            r_quo <= {r_quo[QW-2:0], 1'b1};
                        end else begin
                            r_rem <= rs;
                            r_quo <= {r_quo[QW-2:0], 1'b0};
                        end
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_ACC: begin
                    // r_bit==1: weight pass; then three accumulate passes per axis
                    if (r_bit != '0) begin
                        unique case (r_wsel)
                            2'd0: begin r_a <= mul_r; r_wsel <= 2'd1; end
                            2'd1: begin r_e <= mul_r; r_wsel <= 2'd2; end
                            default: begin
                                logic [2*TF+2:0] bb;
                                bb = (2*TF+3)'(ONE - r_s) * (2*TF+3)'(r_s) * 2
                                   + ((2*TF+3)'(1) << (TF-1));
                                r_b <= bb[2*TF:TF];
                                r_wsel <= 2'd0;
                                r_bit <= '0;
                            end
                        endcase
                    end else begin
                        r_acc <= r_acc + term;
                        if (r_wsel == 2'd2) r_st <= S_OUT;
                        else r_wsel <= r_wsel + 2'd1;
                    end
                end
                S_OUT: begin
                    if (!r_axis) begin
                        r_px <= sat;
                        r_axis <= 1'b1;
                        r_acc <= '0;
                        r_wsel <= 2'd0;
                        r_st <= S_ACC;
                    end else if (out_free) begin
                        r_ox <= r_px;
                        r_oy <= sat;
                        r_oret <= r_first;
                        r_olast <= 1'b0;
                        r_first <= 1'b0;
                        r_k <= r_k + 1'b1;
                        r_st <= S_SDIV;
                    end
                end
                S_END: begin
                    if (r_cnt == 2'd1) r_st <= S_IDLE;
                    else if (out_free) begin
                        r_ox <= OUT_W'(r_x2);
                        r_oy <= OUT_W'(r_y2);
                        r_oret <= r_first && (r_cnt >= 2'd2);
                        r_olast <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> r_ov && $stable(r_ox) && $stable(r_oy))
        else $error("result dropped under stall");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE && i_cmd_valid) |=> r_st != S_IDLE || $past(i_cmd[6*CB+1:6*CB]) == 2'd1)
        else $error("command not started");
    a_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SW) |-> r_k < r_n) else $error("step index past N");
endmodule

>>> rtl/touch_stroke_bezier_smoother.sv
// Top level of the touch stroke Bezier smoother: configuration register, front and back.
// Depends on tsbs_pkg, tsbs_front, tsbs_back.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  input    | i_valid / o_ready        | i_x_pos, i_y_pos, i_release_req
//  result   | o_valid / i_ready        | o_out_x, o_out_y, o_retract_previous, o_last
//  config   | i_cfg_we                 | i_cfg_data (steps per segment)
//
// At default widths a segment runs up to three bit-serial restoring divides, for t and the
// two control points (42 steps each), then per curve sample a bit-serial k/N divide and
// passes of the shared weight multiplier; the back takes no new command until idle again.
// A first point, or a point with fewer than two before it, skips the divides in the back.
// A two-entry command queue lets the front accept samples while the back emits.
// Synchronous active-low reset clears stroke state and restores N to 50.
// A stalled result holds in the output register and the back waits on it.
module touch_stroke_bezier_smoother import tsbs_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [STEP_W-1:0]       i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [11:0]             i_x_pos,
    input  logic [11:0]             i_y_pos,
    input  logic                    i_release_req,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_out_x,
    output logic signed [OUT_W-1:0] o_out_y,
    output logic                    o_retract_previous,
    output logic                    o_last
);
    logic [STEP_W-1:0] r_steps;
    logic cmd_valid, cmd_ready;
    logic [6*COORD_BITS+2-1:0] cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_steps <= STEPS_RESET;
        else if (i_cfg_we) r_steps <= i_cfg_data;
    end

    tsbs_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_x_pos, .i_y_pos, .i_release_req,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    tsbs_back #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_steps(r_steps),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid, .i_ready, .o_out_x, .o_out_y, .o_retract_previous, .o_last
    );
endmodule
